[design/prim_mst_pkg.sv]
// Shared constants and field widths of the Prim spanning tree engine.
package prim_mst_pkg;

  localparam int OPCODE_W = 2;
  localparam int VERTEX_W = 5;
  localparam int WEIGHT_W = 16;
  localparam int COUNT_W  = 6;
  localparam int TOTAL_W  = 21;

  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RUN   = 2'd2;

  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

endpackage

[design/prim_mst_ifs.sv]
// Valid/ready channel interfaces for the command and result streams.
interface prim_mst_cmd_if;
  logic                                       valid;
  logic                                       ready;
  logic        [prim_mst_pkg::OPCODE_W-1:0]   opcode;
  logic        [prim_mst_pkg::VERTEX_W-1:0]   from_vertex;
  logic        [prim_mst_pkg::VERTEX_W-1:0]   to_vertex;
  logic signed [prim_mst_pkg::WEIGHT_W-1:0]   edge_weight;
  logic        [prim_mst_pkg::COUNT_W-1:0]    vertex_count;

  modport source(output valid, opcode, from_vertex, to_vertex, edge_weight, vertex_count,
                 input ready);
  modport sink(input valid, opcode, from_vertex, to_vertex, edge_weight, vertex_count,
               output ready);
endinterface

interface prim_mst_res_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       kind;
  logic        [prim_mst_pkg::VERTEX_W-1:0]   parent_vertex;
  logic        [prim_mst_pkg::VERTEX_W-1:0]   child_vertex;
  logic signed [prim_mst_pkg::WEIGHT_W-1:0]   tree_edge_weight;
  logic signed [prim_mst_pkg::TOTAL_W-1:0]    total_weight;
  logic                                       last;

  modport source(output valid, kind, parent_vertex, child_vertex, tree_edge_weight,
                 total_weight, last, input ready);
  modport sink(input valid, kind, parent_vertex, child_vertex, tree_edge_weight,
               total_weight, last, output ready);
endinterface

[design/prim_minimum_spanning_tree_core.sv]
// Prim minimum spanning tree engine: adjacency memory, candidate table and scan control.
// Clear: 1 beat, then a sweep zeroing all 2**(2*clog2(MAX_VERTICES)) entries, 1024 by default.
// Add: a read-modify-write of the adjacency memory through its one read port.
// Run: one pass per tree vertex over its n neighbor entries (n = clamped vertex count),
// with one adjacency memory read per (vertex, neighbor) pair.
// Reset is synchronous; the block first sweeps the adjacency memory, ready held low.
module prim_minimum_spanning_tree_core #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  prim_mst_cmd_if.sink   cmd,
  prim_mst_res_if.source res
);

  localparam int VB    = $clog2(MAX_VERTICES);
  localparam int CW    = VB + 1;
  localparam int AW    = 2 * VB;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_ADD    = 5'b00100,
    S_PASS   = 5'b01000,
    S_DECIDE = 5'b10000
  } state_t;

  state_t state;

  // Adjacency memory: MSB is the presence bit, the rest the weight.
  logic [WEIGHT_BITS:0] mem [DEPTH];
  logic [WEIGHT_BITS:0] rd_data;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WEIGHT_BITS:0] wr_data;
  logic [AW-1:0]        clr_addr;

  logic [AW-1:0]                add_addr;
  logic signed [WEIGHT_BITS-1:0] add_w;

  // Run state. u is the vertex whose neighbors are being relaxed in this pass.
  logic [CW-1:0]         n;
  logic [VB-1:0]         u;
  logic [CW-1:0]         v;
  logic                  pv;
  logic [VB-1:0]         vd;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] cpres;
  logic [VB-1:0]           cpar [MAX_VERTICES];
  logic signed [WEIGHT_BITS-1:0] cw [MAX_VERTICES];

  logic                          best_found;
  logic [VB-1:0]                 best_v;
  logic [VB-1:0]                 best_p;
  logic signed [WEIGHT_BITS-1:0] best_w;
  logic signed [prim_mst_pkg::TOTAL_W-1:0] total;
  logic signed [prim_mst_pkg::TOTAL_W-1:0] total_next;

  // Output register.
  logic                                     ovalid;
  logic                                     okind;
  logic [prim_mst_pkg::VERTEX_W-1:0]        oparent;
  logic [prim_mst_pkg::VERTEX_W-1:0]        ochild;
  logic signed [prim_mst_pkg::WEIGHT_W-1:0] oweight;
  logic signed [prim_mst_pkg::TOTAL_W-1:0]  ototal;
  logic                                     olast;
  logic                                     load_out;

  logic                          accept;
  logic                          add_ok;
  logic [VB-1:0]                 fidx;
  logic [VB-1:0]                 tidx;
  logic signed [WEIGHT_BITS-1:0] w_in;
  logic [CW-1:0]                 n_in;

  logic                          e_pres;
  logic signed [WEIGHT_BITS-1:0] e_w;
  logic                          relax;
  logic                          new_pres;
  logic [VB-1:0]                 new_p;
  logic signed [WEIGHT_BITS-1:0] new_w;
  logic                          sel;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;

  assign fidx   = VB'(cmd.from_vertex);
  assign tidx   = VB'(cmd.to_vertex);
  assign add_ok = (32'(cmd.from_vertex) < 32'(MAX_VERTICES)) &&
                  (32'(cmd.to_vertex) < 32'(MAX_VERTICES));
  // The weight field is taken as WEIGHT_BITS wide, truncated or zero-extended.
  assign w_in   = WEIGHT_BITS'($unsigned(cmd.edge_weight));

  // Vertex count of zero runs one vertex; counts above the table size are clamped.
  always_comb begin
    if (cmd.vertex_count == '0) begin
      n_in = CW'(1);
    end else if (32'(cmd.vertex_count) > 32'(MAX_VERTICES)) begin
      n_in = CW'(MAX_VERTICES);
    end else begin
      n_in = CW'(cmd.vertex_count);
    end
  end

  always_comb begin
    if (state == S_PASS) begin
      rd_addr = {u, VB'(v)};
    end else begin
      rd_addr = {fidx, tidx};
    end
  end

  // Add keeps the smaller weight of a duplicate entry.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = add_addr;
    wr_data = {1'b1, add_w};
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_ADD: begin
        wr_en = !rd_data[WEIGHT_BITS] || (add_w < $signed(rd_data[WEIGHT_BITS-1:0]));
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Relaxation of the neighbor whose adjacency entry returns this cycle, and the running
  // minimum over the updated candidates. Equal weights keep the lower vertex.
  assign e_pres = rd_data[WEIGHT_BITS];
  assign e_w    = $signed(rd_data[WEIGHT_BITS-1:0]);
  assign relax  = pv && e_pres && !visited[vd] &&
                  (!cpres[vd] || (e_w < cw[vd]) || ((e_w == cw[vd]) && (u < cpar[vd])));
  assign new_pres = cpres[vd] || relax;
  assign new_p    = relax ? u : cpar[vd];
  assign new_w    = relax ? e_w : cw[vd];
  assign sel      = pv && !visited[vd] && new_pres && (!best_found || (new_w < best_w));

  assign total_next = total + prim_mst_pkg::TOTAL_W'(best_w);

  // The decision step loads the output register once the previous beat has gone or
  // is leaving in this cycle.
  assign load_out = (state == S_DECIDE) && (!ovalid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      visited    <= '0;
      cpres      <= '0;
      pv         <= 1'b0;
      best_found <= 1'b0;
      total      <= '0;
      ovalid     <= 1'b0;
    end else begin
      if (load_out) begin
        ovalid <= 1'b1;
      end else if (res.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (cmd.opcode)
              prim_mst_pkg::OP_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              prim_mst_pkg::OP_ADD: begin
                if (add_ok) begin
                  add_addr <= {fidx, tidx};
                  add_w    <= w_in;
                  state    <= S_ADD;
                end
              end
              prim_mst_pkg::OP_RUN: begin
                n          <= n_in;
                u          <= '0;
                v          <= '0;
                visited    <= MAX_VERTICES'(1);
                cpres      <= '0;
                total      <= '0;
                best_found <= 1'b0;
                state      <= S_PASS;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_ADD: begin
          state <= S_IDLE;
        end
        S_PASS: begin
          pv <= (v < n);
          vd <= VB'(v);
          if (v < n) begin
            v <= v + CW'(1);
          end else if (!pv) begin
            state <= S_DECIDE;
          end
          if (relax) begin
            cpres[vd] <= 1'b1;
            cpar[vd]  <= u;
            cw[vd]    <= e_w;
          end
          if (sel) begin
            best_found <= 1'b1;
            best_v     <= vd;
            best_p     <= new_p;
            best_w     <= new_w;
          end
        end
        S_DECIDE: begin
          if (load_out) begin
            if (best_found) begin
              okind           <= prim_mst_pkg::KIND_EDGE;
              oparent         <= prim_mst_pkg::VERTEX_W'(best_p);
              ochild          <= prim_mst_pkg::VERTEX_W'(best_v);
              oweight         <= prim_mst_pkg::WEIGHT_W'(best_w);
              ototal          <= total_next;
              olast           <= 1'b0;
              total           <= total_next;
              u               <= best_v;
              visited[best_v] <= 1'b1;
              best_found      <= 1'b0;
              v               <= '0;
              state           <= S_PASS;
            end else begin
              okind   <= prim_mst_pkg::KIND_TOTAL;
              oparent <= '0;
              ochild  <= '0;
              oweight <= '0;
              ototal  <= total;
              olast   <= 1'b1;
              state   <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid            = ovalid;
  assign res.kind             = okind;
  assign res.parent_vertex    = oparent;
  assign res.child_vertex     = ochild;
  assign res.tree_edge_weight = oweight;
  assign res.total_weight     = ototal;
  assign res.last             = olast;

endmodule

[bench/prim_mst_checker.sv]
// Result checker for the Prim spanning tree engine: tracks the graph and predicts every beat.
`timescale 1ns / 1ps
module prim_mst_checker (
  input  logic   clk,
  input  logic   rst,
  prim_mst_cmd_if cmd,
  prim_mst_res_if res,
  output int     mismatches,
  output int     pending
);

  typedef struct packed {
    logic                                     kind;
    logic [prim_mst_pkg::VERTEX_W-1:0]        parent_vertex;
    logic [prim_mst_pkg::VERTEX_W-1:0]        child_vertex;
    logic signed [prim_mst_pkg::WEIGHT_W-1:0] tree_edge_weight;
    logic signed [prim_mst_pkg::TOTAL_W-1:0]  total_weight;
    logic                                     last;
  } tree_beat_t;

  localparam int NV = 32;

  logic                                     adj_present [NV][NV];
  logic signed [prim_mst_pkg::WEIGHT_W-1:0] adj_weight  [NV][NV];
  tree_beat_t                               tree_beats_q [$];

  // Append one predicted beat at the tail of the queue.
  task automatic queue_beat(input tree_beat_t beat);
    tree_beats_q.insert(tree_beats_q.size(), beat);
  endtask

  // Grow the tree from vertex 0 over the clamped count and queue its edges and the total.
  task automatic grow_tree(input logic [prim_mst_pkg::COUNT_W-1:0] count);
    int                                       n;
    int                                       u;
    int                                       best;
    logic [NV-1:0]                            visited;
    logic                                     cand_ok  [NV];
    int                                       cand_par [NV];
    logic signed [prim_mst_pkg::WEIGHT_W-1:0] cand_w   [NV];
    logic signed [prim_mst_pkg::TOTAL_W-1:0]  total;
    tree_beat_t                               beat;
    n = (count == 0) ? 1 : (count > NV) ? NV : int'(count);
    visited = '0;
    total = '0;
    for (int v = 0; v < NV; v++) cand_ok[v] = 1'b0;
    u = 0;
    forever begin
      visited[u] = 1'b1;
      for (int v = 0; v < n; v++) begin
        if (adj_present[u][v] && !visited[v]) begin
          if (!cand_ok[v] || adj_weight[u][v] < cand_w[v] ||
              (adj_weight[u][v] == cand_w[v] && u < cand_par[v])) begin
            cand_ok[v]  = 1'b1;
            cand_w[v]   = adj_weight[u][v];
            cand_par[v] = u;
          end
        end
      end
      // Ties on weight go to the lowest-numbered vertex.
      best = -1;
      for (int v = 0; v < n; v++) begin
        if (!visited[v] && cand_ok[v] && (best < 0 || cand_w[v] < cand_w[best]))
          best = v;
      end
      if (best < 0) break;
      total = total + prim_mst_pkg::TOTAL_W'(cand_w[best]);
      beat.kind             = prim_mst_pkg::KIND_EDGE;
      beat.parent_vertex    = prim_mst_pkg::VERTEX_W'(cand_par[best]);
      beat.child_vertex     = prim_mst_pkg::VERTEX_W'(best);
      beat.tree_edge_weight = cand_w[best];
      beat.total_weight     = total;
      beat.last             = 1'b0;
      queue_beat(beat);
      u = best;
    end
    beat.kind             = prim_mst_pkg::KIND_TOTAL;
    beat.parent_vertex    = '0;
    beat.child_vertex     = '0;
    beat.tree_edge_weight = '0;
    beat.total_weight     = total;
    beat.last             = 1'b1;
    queue_beat(beat);
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    for (int a = 0; a < NV; a++)
      for (int b = 0; b < NV; b++) adj_present[a][b] = 1'b0;
  end

  always @(posedge clk) begin
    tree_beat_t want;
    tree_beat_t got;
    if (!rst) begin
      if (res.valid && res.ready) begin
        got = '{res.kind, res.parent_vertex, res.child_vertex, res.tree_edge_weight,
                res.total_weight, res.last};
        if (tree_beats_q.size() == 0) begin
          if (mismatches < 10)
            $display("ERROR: unexpected result beat %p", got);
          mismatches++;
        end else begin
          want = tree_beats_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("ERROR: result mismatch, expected %p, got %p", want, got);
            mismatches++;
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        case (cmd.opcode)
          prim_mst_pkg::OP_CLEAR: begin
            for (int a = 0; a < NV; a++)
              for (int b = 0; b < NV; b++) adj_present[a][b] = 1'b0;
          end
          prim_mst_pkg::OP_ADD: begin
            // A duplicate entry keeps the smaller weight.
            if (!adj_present[cmd.from_vertex][cmd.to_vertex] ||
                cmd.edge_weight < adj_weight[cmd.from_vertex][cmd.to_vertex]) begin
              adj_present[cmd.from_vertex][cmd.to_vertex] = 1'b1;
              adj_weight[cmd.from_vertex][cmd.to_vertex]  = cmd.edge_weight;
            end
          end
          prim_mst_pkg::OP_RUN: grow_tree(cmd.vertex_count);
          default: ;
        endcase
      end
      pending = tree_beats_q.size();
    end
  end
endmodule

[bench/testbench.sv]
// Top of the Prim spanning tree bench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

  // Longest stretch with no beat on either channel; it leaves a wide margin over a clear
  // sweep or a full 32-vertex run.
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 100;
  // Opcode with no meaning; the engine takes the beat and does nothing.
  localparam logic [prim_mst_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  int   quiet_cycles;
  int   sent_items;
  // Once set, neither side idles, so the tail of the run goes at full rate.
  logic calm;

  prim_mst_cmd_if cmd_ch();
  prim_mst_res_if res_ch();

  prim_minimum_spanning_tree_core u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  prim_mst_checker u_checker (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .mismatches(mismatches),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one command beat and hold it until the engine takes it. Outside the calm
  // tail, a random burst of idle cycles sometimes comes first.
  task automatic send_cmd(input logic [prim_mst_pkg::OPCODE_W-1:0] op, input int from_v,
                          input int to_v, input int weight, input int count);
    if (!calm && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    cmd_ch.valid        = 1'b1;
    cmd_ch.opcode       = op;
    cmd_ch.from_vertex  = prim_mst_pkg::VERTEX_W'(from_v);
    cmd_ch.to_vertex    = prim_mst_pkg::VERTEX_W'(to_v);
    cmd_ch.edge_weight  = prim_mst_pkg::WEIGHT_W'(weight);
    cmd_ch.vertex_count = prim_mst_pkg::COUNT_W'(count);
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
    if (op != OP_UNUSED) sent_items++;
  endtask

  // Random weight: mostly a narrow band so that ties are frequent, else the full range.
  function automatic int pick_weight();
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 6) - 3;
  endfunction

  // Command stimulus.
  initial begin
    int n;
    int adds;
    rst = 1'b1;
    calm = 1'b0;
    sent_items = 0;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = prim_mst_pkg::OP_CLEAR;
    cmd_ch.from_vertex = '0;
    cmd_ch.to_vertex = '0;
    cmd_ch.edge_weight = '0;
    cmd_ch.vertex_count = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: weight extremes, a duplicate that lowers the weight, equal-weight
    // ties resolved by parent and by vertex, an unknown opcode, count clamping at both
    // ends, a disconnected graph and an empty one.
    send_cmd(prim_mst_pkg::OP_CLEAR, 0, 0, 0, 0);
    send_cmd(prim_mst_pkg::OP_ADD, 0, 1, 32767, 0);
    send_cmd(prim_mst_pkg::OP_ADD, 0, 1, -32768, 0);
    send_cmd(prim_mst_pkg::OP_ADD, 0, 2, 5, 0);
    send_cmd(prim_mst_pkg::OP_ADD, 1, 2, 5, 0);
    send_cmd(prim_mst_pkg::OP_ADD, 0, 3, 5, 0);
    send_cmd(prim_mst_pkg::OP_ADD, 2, 3, 32767, 0);
    send_cmd(prim_mst_pkg::OP_ADD, 31, 30, -1, 0);
    send_cmd(prim_mst_pkg::OP_ADD, 3, 31, 0, 0);
    send_cmd(prim_mst_pkg::OP_ADD, 30, 31, 0, 0);
    send_cmd(OP_UNUSED, 31, 31, -1, 63);
    send_cmd(prim_mst_pkg::OP_RUN, 31, 31, 0, 0);
    send_cmd(prim_mst_pkg::OP_RUN, 0, 0, 0, 4);
    send_cmd(prim_mst_pkg::OP_RUN, 0, 0, 0, 63);
    send_cmd(prim_mst_pkg::OP_RUN, 0, 0, 0, 32);
    send_cmd(prim_mst_pkg::OP_RUN, 0, 0, 0, 33);
    send_cmd(prim_mst_pkg::OP_CLEAR, 0, 0, 0, 0);
    send_cmd(prim_mst_pkg::OP_RUN, 0, 0, 0, 2);

    // Random part: a graph on a few vertices, cleared first half the time and filled with
    // random entries, then a run over it; some noise entries and odd counts mixed in.
    while (sent_items < RANDOM_ITEMS) begin
      if (sent_items > RANDOM_ITEMS - 25) calm = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(2, 8);
      if ($urandom_range(0, 1) == 0) send_cmd(prim_mst_pkg::OP_CLEAR, 0, 0, 0, 0);
      adds = $urandom_range(n, 2 * n);
      for (int i = 0; i < adds; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_cmd(prim_mst_pkg::OP_ADD, $urandom_range(0, 31), $urandom_range(0, 31),
                   pick_weight(), 0);
        else
          send_cmd(prim_mst_pkg::OP_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                   pick_weight(), $urandom_range(0, 63));
      end
      if ($urandom_range(0, 9) == 0) send_cmd(OP_UNUSED, 0, 0, pick_weight(), 0);
      send_cmd(prim_mst_pkg::OP_RUN, $urandom_range(0, 31), $urandom_range(0, 31),
               pick_weight(), ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : n);
    end
    cmd_ch.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: once the first result beat shows up, a long hold so that the engine
  // backs up and stalls its command input, then random stall bursts until the calm tail.
  initial begin
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst || !res_ch.valid) @(negedge clk);
    for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
    forever begin
      res_ch.ready = 1'b1;
      @(negedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        res_ch.ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
    end
  end

  // Watchdog: any beat on either channel restarts the count.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end
endmodule
